// ===== rtl/cset_pkg.sv =====
package cset_pkg;

   // Widths fixed by the event and result formats.
   localparam int ID_W        = 6;
   localparam int STAMP_W     = 32;
   localparam int COUNT_W     = 7;
   localparam int ERR_W       = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;

   // Event kinds carried on req_tuser.
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_END   = 1'b1;

   // Sticky error codes.
   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

   // Command from the sequencer to the call stack.
   typedef struct packed {
      logic            rd_en;
      logic            push;
      logic            pop;
      logic [ID_W-1:0] push_id;
   } stk_cmd_type;

   // Status of the call stack.
   typedef struct packed {
      logic empty;
      logic full;
   } stk_stat_type;

   // Control from the sequencer to the time table.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } tbl_ctl_type;

endpackage

// ===== rtl/cset_stack.sv =====
module cset_stack #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cset_pkg::stk_cmd_type cmd,
   output cset_pkg::stk_stat_type stat,
   output logic [cset_pkg::ID_W-1:0] top_id
);
   import cset_pkg::*;

   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
   localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(STACK_DEPTH);

   logic [ID_W-1:0]    mem [STACK_DEPTH];
   logic [ID_W-1:0]    top_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic [LEVEL_W-1:0] below;

   assign stat.empty = (level_ff == '0);
   assign stat.full  = (level_ff == FULL_LEVEL);
   assign below      = level_ff - LEVEL_W'(1);
   assign top_id     = top_ff;

   // Stack memory: the top entry is read into a register ahead of its use.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         top_ff <= mem[below[ADDR_W-1:0]];
      end
      if (cmd.push && !stat.full) begin
         mem[level_ff[ADDR_W-1:0]] <= cmd.push_id;
      end
   end

   // Fill level: a push on a full stack and a pop on an empty one are dropped.
   always_comb begin
      level_in = level_ff;
      if (cmd.push && !stat.full) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (cmd.pop && !stat.empty) begin
         level_in = below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

endmodule

// ===== rtl/cset_table.sv =====
module cset_table #(
   parameter int MAX_FUNCS = 64,
   parameter int TIME_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cset_pkg::tbl_ctl_type        ctl,
   input  logic [$clog2(MAX_FUNCS)-1:0] rd_addr,
   input  logic [$clog2(MAX_FUNCS)-1:0] wr_addr,
   input  logic [TIME_BITS-1:0]         wr_data,
   output logic [TIME_BITS-1:0]         rd_data
);
   import cset_pkg::*;

   logic [TIME_BITS-1:0] mem [MAX_FUNCS];
   logic [TIME_BITS-1:0] data_ff;
   logic                 hit_ff;
   logic [MAX_FUNCS-1:0] valid_ff;
   logic [MAX_FUNCS-1:0] valid_in;

   // Accumulator memory with a registered read port.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         data_ff <= mem[rd_addr];
      end
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // One valid bit per entry; an entry never written since the last clear reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

// ===== rtl/call_stack_exclusive_time_unit.sv =====
// Channel | Direction | Handshake         | Content
// req     | in        | tvalid / tready   | tdata: func_id, timestamp; tuser: mode; tlast: last event
// rsp     | out       | tvalid / tready   | tdata: report_id, exclusive_time, error_code; tlast
// csr     | in        | wr_en             | wr_data: function_count
//
// An event is handled in order: stack top read, accumulator read, then the
// read-modify-write of the accumulator together with the push or pop.
// After a last event, each reported function goes through a table read and a load
// of the output register; the table read waits while the output register waits on rsp_tready.
// The synchronous reset clears the stack level, the time mark, the errors and
// the table valid bits at once; no clearing pass is needed.
module call_stack_exclusive_time_unit #(
   parameter int MAX_FUNCS   = 64,
   parameter int STACK_DEPTH = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [5:0] func_id, [37:6] timestamp, [39:38] zero
   input  logic [cset_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] mode
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [5:0] report_id, [37:6] exclusive_time, [39:38] error_code
   output logic [cset_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [cset_pkg::COUNT_W-1:0]        csr_wr_data
);
   import cset_pkg::*;

   localparam int FIDX_W = $clog2(MAX_FUNCS);
   localparam int MARK_W = TIME_BITS + 1;
   localparam int SUM_W  = TIME_BITS + 2;
   localparam logic [COUNT_W-1:0] FUNCS_C = COUNT_W'(MAX_FUNCS);
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TOP    = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_RPT_RD = 3'd3;
   localparam logic [2:0] ST_RPT_LD = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic                 mode_ff;
   logic                 last_ff;
   logic [ID_W-1:0]      id_ff;
   logic [TIME_BITS-1:0] stamp_ff;
   logic [TIME_BITS-1:0] stamp_in;
   logic                 has_top_ff;
   logic                 id_ok_ff;
   logic [MARK_W-1:0]    mark_ff, mark_in;
   logic [ERR_W-1:0]     err_ff, err_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [FIDX_W-1:0]    k_ff, k_in;
   logic [FIDX_W-1:0]    last_k_ff, last_k_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [STAMP_W-1:0]   rsp_time_ff, rsp_time_in;
   logic [ERR_W-1:0]     rsp_err_ff;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 out_free;
   logic [ID_W-1:0]      top_id;
   logic [MARK_W-1:0]    now;
   logic [MARK_W-1:0]    elapsed;
   logic [SUM_W-1:0]     sum;
   logic [TIME_BITS-1:0] acc_new;
   logic [TIME_BITS-1:0] acc_rd;
   logic                 do_charge;
   logic [FIDX_W-1:0]    tbl_rd_addr;

   stk_cmd_type  stk_cmd;
   stk_stat_type stk_stat;
   tbl_ctl_type  tbl_ctl;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Timestamp and result time at the configured time width.
   generate
      if (TIME_BITS <= STAMP_W) begin : g_narrow
         assign stamp_in    = req_tdata[ID_W +: TIME_BITS];
         assign rsp_time_in = STAMP_W'(acc_rd);
      end else begin : g_wide
         assign stamp_in    = TIME_BITS'(req_tdata[ID_W +: STAMP_W]);
         assign rsp_time_in = acc_rd[STAMP_W-1:0];
      end
   endgenerate

   cset_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stk_cmd),
      .stat   (stk_stat),
      .top_id (top_id)
   );

   cset_table #(
      .MAX_FUNCS (MAX_FUNCS),
      .TIME_BITS (TIME_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .rd_addr (tbl_rd_addr),
      .wr_addr (top_id[FIDX_W-1:0]),
      .wr_data (acc_new),
      .rd_data (acc_rd)
   );

   // Charge arithmetic: end times are inclusive, so an end event counts one more.
   assign now       = {1'b0, stamp_ff} + MARK_W'(mode_ff == MODE_END);
   assign elapsed   = now - mark_ff;
   assign sum       = {2'b00, acc_rd} + {1'b0, elapsed};
   assign acc_new   = (sum[SUM_W-1:TIME_BITS] != '0) ? TIME_MAX : sum[TIME_BITS-1:0];
   assign do_charge = has_top_ff && id_ok_ff && (now > mark_ff);

   // Sequencer: event update and report walk.
   always_comb begin
      state_in     = state_ff;
      mark_in      = mark_ff;
      err_in       = err_ff;
      k_in         = k_ff;
      last_k_in    = last_k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      stk_cmd      = '0;
      stk_cmd.push_id = id_ff;
      tbl_ctl      = '0;
      tbl_rd_addr  = top_id[FIDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               stk_cmd.rd_en = 1'b1;
               state_in      = ST_TOP;
            end
         end
         ST_TOP: begin
            tbl_ctl.rd_en = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            tbl_ctl.wr_en = do_charge;
            mark_in       = now;
            if (mode_ff == MODE_START) begin
               stk_cmd.push = 1'b1;
               if (stk_stat.full && err_ff == ERR_NONE) begin
                  err_in = ERR_OVERFLOW;
               end
            end else begin
               stk_cmd.pop = 1'b1;
               if (stk_stat.empty && err_ff == ERR_NONE) begin
                  err_in = ERR_UNDERFLOW;
               end
            end
            if (last_ff) begin
               k_in = '0;
               if (count_ff == '0) begin
                  last_k_in = '0;
               end else if (count_ff >= FUNCS_C) begin
                  last_k_in = FIDX_W'(MAX_FUNCS - 1);
               end else begin
                  last_k_in = FIDX_W'(count_ff - COUNT_W'(1));
               end
               state_in = ST_RPT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RPT_RD: begin
            tbl_rd_addr = k_ff;
            if (out_free) begin
               tbl_ctl.rd_en = 1'b1;
               state_in      = ST_RPT_LD;
            end
         end
         ST_RPT_LD: begin
            rsp_valid_in = 1'b1;
            if (k_ff == last_k_ff) begin
               tbl_ctl.clear = 1'b1;
               err_in        = ERR_NONE;
               state_in      = ST_IDLE;
            end else begin
               k_in     = k_ff + FIDX_W'(1);
               state_in = ST_RPT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mark_ff      <= '0;
         err_ff       <= ERR_NONE;
         count_ff     <= FUNCS_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_ff      <= mark_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // Event fields and walk position.
   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      last_k_ff <= last_k_in;
      if (req_fire) begin
         mode_ff    <= req_tuser;
         id_ff      <= req_tdata[ID_W-1:0];
         stamp_ff   <= stamp_in;
         last_ff    <= req_tlast;
         has_top_ff <= !stk_stat.empty;
      end
      if (state_ff == ST_TOP) begin
         id_ok_ff <= ({1'b0, top_id} < FUNCS_C);
      end
   end

   // Output register, loaded once per reported function.
   always_ff @(posedge clock) begin
      if (state_ff == ST_RPT_LD) begin
         rsp_id_ff   <= ID_W'(k_ff);
         rsp_time_ff <= rsp_time_in;
         rsp_err_ff  <= err_ff;
         rsp_last_ff <= (k_ff == last_k_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_err_ff, rsp_time_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/cset_checker.sv =====
module cset_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cset_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import cset_pkg::*;

   // No result is pending right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // An event that does not close the trace never starts a report.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("result after an event that is not last");

   // Inside a report the block takes no new event.
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("event taken in the middle of a report");

   // A result that follows the final result of a report opens a new report at function zero.
   a_first_id: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && $past(rsp_tlast) |-> rsp_tdata[ID_W-1:0] == '0)
      else $error("report does not start at function zero");

endmodule

bind call_stack_exclusive_time_unit cset_checker u_cset_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
   import cset_pkg::*;

   localparam int FUNC_SLOTS    = 64;
   localparam int STACK_SLOTS   = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 10;

   // One expected report transfer.
   typedef struct {
      logic [ID_W-1:0]    func_id;
      logic [STAMP_W-1:0] busy_time;
      logic               final_entry;
      logic [ERR_W-1:0]   err;
   } report_entry_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = MODE_START;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0]    csr_wr_data = '0;

   // Predicted state of the block.
   logic [ID_W-1:0]    call_ids [STACK_SLOTS];
   int                 call_depth = 0;
   logic [STAMP_W:0]   time_mark = '0;
   logic [STAMP_W-1:0] busy_totals [FUNC_SLOTS] = '{default: '0};
   logic [ERR_W-1:0]   sticky_err = ERR_NONE;
   int                 report_len = FUNC_SLOTS;
   report_entry_type   pending_reports [$];

   int                 burst_left = 0;
   logic [STAMP_W-1:0] stamp_now = '0;
   logic [9:0]         ready_phase = '0;
   int                 cycle_count = 0;
   int                 fail_count = 0;
   report_entry_type   oldest_report;

   call_stack_exclusive_time_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Add elapsed time to one function's total, saturating at the top of the range.
   // Ids are six bits wide, so every id has a slot in the table.
   function automatic void charge_busy_time(input logic [ID_W-1:0] id,
                                            input logic [STAMP_W:0] now);
      logic [STAMP_W+1:0] sum;
      if (now <= time_mark) return;
      sum = {1'b0, busy_totals[id]} + (now - time_mark);
      busy_totals[id] = (sum > {2'b00, {STAMP_W{1'b1}}}) ? '1 : sum[STAMP_W-1:0];
   endfunction

   // Apply one trace event to the predicted state and queue the report it causes.
   function automatic void apply_trace_event(input logic mode, input logic [ID_W-1:0] id,
                                             input logic [STAMP_W-1:0] stamp,
                                             input logic last);
      logic [STAMP_W:0] end_mark;
      report_entry_type entry;
      if (mode == MODE_START) begin
         if (call_depth > 0) charge_busy_time(call_ids[call_depth-1], {1'b0, stamp});
         if (call_depth < STACK_SLOTS) begin
            call_ids[call_depth] = id;
            call_depth++;
         end else if (sticky_err == ERR_NONE) begin
            sticky_err = ERR_OVERFLOW;
         end
         time_mark = {1'b0, stamp};
      end else begin
         // End times are inclusive, so the charge runs up to one past the stamp.
         end_mark = {1'b0, stamp} + 1'b1;
         if (call_depth > 0) begin
            charge_busy_time(call_ids[call_depth-1], end_mark);
            call_depth--;
         end else if (sticky_err == ERR_NONE) begin
            sticky_err = ERR_UNDERFLOW;
         end
         time_mark = end_mark;
      end
      if (last) begin
         for (int k = 0; k < report_len; k++) begin
            entry.func_id     = k[ID_W-1:0];
            entry.busy_time   = busy_totals[k];
            entry.final_entry = (k == report_len - 1);
            entry.err         = sticky_err;
            pending_reports   = {pending_reports, entry};
         end
         busy_totals = '{default: '0};
         sticky_err  = ERR_NONE;
      end
   endfunction

   // Send one event, with bursts of back-to-back transfers and random gaps between them.
   task automatic send_event(input logic mode, input logic [ID_W-1:0] id,
                             input logic [STAMP_W-1:0] stamp, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, stamp, id};
      req_tuser  <= mode;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      apply_trace_event(mode, id, stamp, last);
   endtask

   // Wait until every report has arrived and the last event has left the pipeline.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_function_count(input logic [COUNT_W-1:0] value);
      wait_for_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (value == 0) report_len = 1;
      else if (value > FUNC_SLOTS) report_len = FUNC_SLOTS;
      else report_len = int'(value);
   endtask

   // Hand-built traces for the corner cases.
   task automatic test_directed_trace();
      // The reset count reports the whole table; nesting, then an end on an empty stack.
      send_event(MODE_START, 6'd5, 32'd10, 1'b0);
      send_event(MODE_START, 6'd63, 32'd15, 1'b0);
      send_event(MODE_END, 6'd0, 32'd20, 1'b0);
      send_event(MODE_END, 6'd63, 32'd30, 1'b0);
      send_event(MODE_END, 6'd42, 32'd40, 1'b0);
      send_event(MODE_START, 6'd0, 32'd41, 1'b0);
      send_event(MODE_END, 6'd0, 32'd50, 1'b1);
      // Single-entry report; the nested start steps back in time.
      write_function_count(7'd1);
      send_event(MODE_START, 6'd0, 32'd100, 1'b0);
      send_event(MODE_START, 6'd1, 32'd90, 1'b0);
      send_event(MODE_END, 6'd1, 32'd95, 1'b0);
      send_event(MODE_END, 6'd0, 32'd200, 1'b1);
      // A count of zero still reports one function; the total saturates.
      write_function_count(7'd0);
      send_event(MODE_START, 6'd0, 32'h0000_0000, 1'b0);
      send_event(MODE_END, 6'd0, 32'hFFFF_FFFF, 1'b0);
      send_event(MODE_START, 6'd0, 32'h0000_0000, 1'b0);
      send_event(MODE_END, 6'd0, 32'h0000_1000, 1'b1);
      // A count above the table size; an end at the top stamp pushes the mark past 32 bits.
      write_function_count(7'd127);
      send_event(MODE_START, 6'd62, 32'h8000_0000, 1'b0);
      send_event(MODE_START, 6'd63, 32'hFFFF_FFFE, 1'b0);
      send_event(MODE_END, 6'd63, 32'hFFFF_FFFF, 1'b0);
      send_event(MODE_START, 6'd1, 32'h0000_0005, 1'b0);
      send_event(MODE_END, 6'd1, 32'h0000_0010, 1'b0);
      send_event(MODE_END, 6'd62, 32'h0000_0020, 1'b1);
      stamp_now = 32'h0000_0020;
   endtask

   // Fill the stack past its depth, report, then unwind it past empty.
   task automatic test_stack_overflow();
      write_function_count(7'd2);
      for (int n = 0; n <= STACK_SLOTS; n++) begin
         stamp_now = stamp_now + $urandom_range(0, 9);
         send_event(MODE_START, ID_W'($urandom_range(0, 63)), stamp_now, n == STACK_SLOTS);
      end
      for (int n = 0; n <= STACK_SLOTS; n++) begin
         stamp_now = stamp_now + $urandom_range(0, 9);
         send_event(MODE_END, ID_W'($urandom_range(0, 63)), stamp_now, n == STACK_SLOTS);
      end
   endtask

   // Random traces: mostly forward time and well-formed nesting, with some noise.
   task automatic test_random_traces(input int target);
      int                 sent;
      int                 trace_len;
      int                 pick;
      logic               mode;
      logic [ID_W-1:0]    id;
      logic [COUNT_W-1:0] count_value;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) count_value = 7'd0;
            else if (pick == 1) count_value = 7'd64;
            else if (pick == 2) count_value = COUNT_W'($urandom_range(65, 127));
            else count_value = COUNT_W'($urandom_range(1, 8));
            write_function_count(count_value);
         end
         trace_len = $urandom_range(3, 16);
         for (int n = 0; n < trace_len; n++) begin
            if (call_depth == 0) begin
               mode = ($urandom_range(0, 19) == 0) ? MODE_END : MODE_START;
            end else if (call_depth >= 12) begin
               mode = ($urandom_range(0, 3) == 0) ? MODE_START : MODE_END;
            end else begin
               mode = ($urandom_range(0, 1) == 0) ? MODE_START : MODE_END;
            end
            if ($urandom_range(0, 3) == 0) id = ID_W'($urandom_range(0, 63));
            else id = ID_W'($urandom_range(0, report_len - 1));
            pick = $urandom_range(0, 31);
            if (pick == 0) stamp_now = $urandom();
            else if (pick == 1) stamp_now = stamp_now - $urandom_range(1, 20);
            else stamp_now = stamp_now + $urandom_range(0, 40);
            send_event(mode, id, stamp_now, n == trace_len - 1);
            sent++;
         end
      end
   endtask

   // Receiver stall pattern: always ready, mostly ready, rarely ready, coin flip.
   always @(posedge clock) begin
      ready_phase <= ready_phase + 1'b1;
      case (ready_phase[9:8])
         2'd0: begin
            rsp_tready <= 1'b1;
         end
         2'd1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2'd2: begin
            rsp_tready <= (ready_phase[2:0] == 3'd0);
         end
         default: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
      endcase
   end

   // Compare each report transfer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            $error("report transfer with nothing pending: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_tdata[5:0] !== oldest_report.func_id) begin
               $error("report_id: expected %0d, actual %0d",
                      oldest_report.func_id, rsp_tdata[5:0]);
               fail_count++;
            end
            if (rsp_tdata[37:6] !== oldest_report.busy_time) begin
               $error("exclusive_time: expected %0d, actual %0d",
                      oldest_report.busy_time, rsp_tdata[37:6]);
               fail_count++;
            end
            if (rsp_tdata[39:38] !== oldest_report.err) begin
               $error("error_code: expected %0d, actual %0d",
                      oldest_report.err, rsp_tdata[39:38]);
               fail_count++;
            end
            if (rsp_tlast !== oldest_report.final_entry) begin
               $error("last_result: expected %0d, actual %0d",
                      oldest_report.final_entry, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[call_stack_exclusive_time_unit] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_trace();
      test_stack_overflow();
      test_random_traces(20);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[call_stack_exclusive_time_unit] OK");
      end else begin
         $display("[call_stack_exclusive_time_unit] ERROR");
      end
      $finish;
   end

endmodule
